@@ src/spq_pkg.sv @@
// Shared types, widths and codes for the stable priority queue.
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int PRIO_W       = 16;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 5;

    // Request operation codes.
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Controller states: no result pending, or a result held for the sink.
    typedef enum logic
    {
        ST_IDLE,
        ST_HOLD
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic                enq;
        logic                deq;
        logic                load;
        logic [STATUS_W-1:0] status;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic full;
        logic empty;
    } dp_stat_t;

endpackage

@@ src/spq_if.sv @@
// Request and result channel interfaces of the stable priority queue.
interface spq_req_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  priority_req;

    modport source (output valid, output cmd, output value, output priority_req, input ready);
    modport sink (input valid, input cmd, input value, input priority_req, output ready);
endinterface

interface spq_rsp_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] out_value;
    logic signed [PRIO_W-1:0]  out_priority;
    logic [STATUS_W-1:0]       status;
    logic [FILL_W-1:0]         fill_level;

    modport source (output valid, output out_value, output out_priority, output status,
                    output fill_level, input ready);
    modport sink (input valid, input out_value, input out_priority, input status,
                  input fill_level, output ready);
endinterface

@@ src/spq_ctl.sv @@
// Controller of the stable priority queue: handshakes and operation decode.
module spq_ctl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_cmd,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t dp_stat,
    output ctl_cmd_t ctl_cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A new request fills the result register; a taken result empties it.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_ready && !accept)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        ctl_cmd        = '0;
        ctl_cmd.status = STAT_DONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_HOLD:
            begin
                in_ready  = out_ready;
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        // The handshake is formed from the ready computed just above.
        ctl_cmd.load = in_valid && in_ready;
        if (in_valid && in_ready)
        begin
            if (in_cmd == CMD_ENQ)
            begin
                if (dp_stat.full)
                begin
                    ctl_cmd.status = STAT_FULL;
                end
                else
                begin
                    ctl_cmd.enq = 1'b1;
                end
            end
            else
            begin
                if (dp_stat.empty)
                begin
                    ctl_cmd.status = STAT_EMPTY;
                end
                else
                begin
                    ctl_cmd.deq = 1'b1;
                end
            end
        end
    end

endmodule

@@ src/spq_dp.sv @@
// Datapath of the stable priority queue: sorted cell array and result register.
module spq_dp
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctl_cmd_t                  ctl_cmd,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic signed [PRIO_W-1:0]  in_prio,
    output dp_stat_t                  dp_stat,
    output logic signed [VALUE_W-1:0] out_value,
    output logic signed [PRIO_W-1:0]  out_priority,
    output logic [STATUS_W-1:0]       status,
    output logic [FILL_W-1:0]         fill_level
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] val_reg [CAPACITY];
    logic signed [PRIO_W-1:0]  prio_reg [CAPACITY];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CAPACITY-1:0]       le;

    logic signed [VALUE_W-1:0] out_value_reg;
    logic signed [PRIO_W-1:0]  out_priority_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [FILL_W-1:0]         fill_reg;
    logic [CNT_W+FILL_W-1:0]   fill_wide;

    assign dp_stat.full  = (count_reg == CNT_W'(CAPACITY));
    assign dp_stat.empty = (count_reg == '0);

    // Each cell compares its own priority; the cells that stay in front form a prefix.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

        assign le[i] = (IDX < count_reg) && (prio_reg[i] <= in_prio);

        always_ff @(posedge clk)
        begin
            if (ctl_cmd.enq && !le[i])
            begin
                if (i == 0)
                begin
                    val_reg[i]  <= in_value;
                    prio_reg[i] <= in_prio;
                end
                else
                begin
                    if (le[(i == 0) ? 0 : i - 1])
                    begin
                        val_reg[i]  <= in_value;
                        prio_reg[i] <= in_prio;
                    end
                    else
                    begin
                        val_reg[i]  <= val_reg[(i == 0) ? 0 : i - 1];
                        prio_reg[i] <= prio_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
            else if (ctl_cmd.deq && (i < CAPACITY - 1))
            begin
                val_reg[i]  <= val_reg[(i < CAPACITY - 1) ? i + 1 : i];
                prio_reg[i] <= prio_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl_cmd.enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl_cmd.deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign fill_wide = {{FILL_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_cmd.load)
        begin
            out_value_reg    <= ctl_cmd.deq ? val_reg[0] : '0;
            out_priority_reg <= ctl_cmd.deq ? prio_reg[0] : '0;
            status_reg       <= ctl_cmd.status;
            fill_reg         <= fill_wide[FILL_W-1:0];
        end
    end

    assign out_value    = out_value_reg;
    assign out_priority = out_priority_reg;
    assign status       = status_reg;
    assign fill_level   = fill_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_one_op : assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl_cmd.enq && ctl_cmd.deq))
        else $error("enqueue and dequeue issued together");

    a_enq_grows : assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.enq |=> count_reg == $past(count_reg) + 1'b1)
        else $error("enqueue did not grow the store");

    a_front_sorted : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (prio_reg[0] <= prio_reg[1]))
        else $error("front entries out of priority order");

endmodule

@@ src/stable_priority_queue.sv @@
// Top level of the stable priority queue.
//
// The queue keeps up to CAPACITY entries sorted by ascending signed priority in
// a row of compare-and-shift cells, so equal priorities leave in arrival order.
// For every request the cells all compare the incoming priority against their
// own in parallel and then either hold, take the new entry or take their
// neighbor's, and the result is loaded into an output register in the same
// cycle. One request is accepted per cycle, also while a result still waits
// in that register, as long as the sink takes it in the same cycle; the sink's
// ready alone sets the rate. Each request yields exactly one result: an
// enqueue into a full store is rejected with status 1 and a dequeue from an
// empty store answers status 2, both with zero value and priority. The fill
// level is the entry count after the request, low five bits. The store needs
// no clearing after reset; only filled cells are read.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    // The controller owns both handshakes and decides what the request does.
    spq_ctl u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_cmd    (req.cmd),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .dp_stat   (dp_stat),
        .ctl_cmd   (ctl_cmd)
    );

    // The datapath holds the sorted cells and the result register.
    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_cmd      (ctl_cmd),
        .in_value     (req.value),
        .in_prio      (req.priority_req),
        .dp_stat      (dp_stat),
        .out_value    (rsp.out_value),
        .out_priority (rsp.out_priority),
        .status       (rsp.status),
        .fill_level   (rsp.fill_level)
    );

endmodule
